### design/qes_pkg.sv
// Shared constants and types for the quadrature encoder speed block.
package qes_pkg;

  localparam int unsigned SCALE_W   = 40;
  localparam int unsigned STEP_W    = 31;
  localparam int unsigned GAIN_W    = 9;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DW    = 40;
  localparam int unsigned SPD_W     = 32;
  localparam int unsigned POS_OUT_W = 32;

  localparam logic [GAIN_W-1:0] GAIN_ONE = 9'd256;

  localparam logic [SCALE_W-1:0] SCALE_RST = 40'd347773585;
  localparam logic [STEP_W-1:0]  STEP_RST  = 31'd25600;
  localparam logic [GAIN_W-1:0]  GAIN_RST  = 9'd77;

  localparam logic [SPD_W-1:0] SPD_MAX = 32'h7FFF_FFFF;
  localparam logic [SPD_W-1:0] SPD_MIN = 32'h8000_0000;

  typedef enum logic [1:0] {
    ACT_EDGE_A  = 2'd0,
    ACT_EDGE_B  = 2'd1,
    ACT_SPEED   = 2'd2,
    ACT_FLAG    = 2'd3
  } act_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPEED_SCALE = 2'd0,
    CFG_MAX_STEP    = 2'd1,
    CFG_FILT_GAIN   = 2'd2,
    CFG_REVERSE     = 2'd3
  } cfg_idx_e;

endpackage

### design/qes_div.sv
// Restoring serial divider, one quotient bit per cycle.
module qes_div #(
  parameter int unsigned DVD_W = 40,
  parameter int unsigned DVS_W = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DVD_W-1:0] quotient_o
);

  localparam int unsigned CNT_W = $clog2(DVD_W + 1);

  logic [CNT_W-1:0] cnt_q;
  logic             done_q;
  logic [DVS_W-1:0] rem_q;
  logic [DVS_W-1:0] dvs_q;
  logic [DVD_W-1:0] quo_q;
  logic [DVS_W:0]   shifted;
  logic [DVS_W:0]   dvs_ext;
  logic             ge;
  logic [DVS_W:0]   sub;

  assign shifted = {rem_q, quo_q[DVD_W-1]};
  assign dvs_ext = {1'b0, dvs_q};
  assign ge      = shifted >= dvs_ext;
  assign sub     = shifted - dvs_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CNT_W'(DVD_W);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvs_q <= divisor_i;
      quo_q <= dividend_i;
    end else if (cnt_q != '0) begin
      rem_q <= ge ? sub[DVS_W-1:0] : shifted[DVS_W-1:0];
      quo_q <= {quo_q[DVD_W-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

### design/quadrature_encoder_speed_top.sv
// Quadrature encoder channel: position count, edge period and filtered speed.
// Edge beats, flag queries and speed queries without a measured period have their
// result registered at acceptance. A speed query with a measured period runs the serial
// divider that forms scale/dt one quotient bit per cycle, then takes one step each for
// saturation, slew clamp, filter multiply, filter add and result load. in_stall_o stays
// high while a query is in flight or a result waits on a stalled output.
module quadrature_encoder_speed_top #(
  parameter int unsigned COUNT_WIDTH = 32,
  parameter int unsigned TIME_WIDTH  = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [qes_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [qes_pkg::CFG_DW-1:0]      cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [1:0]                      action_i,
  input  logic                            level_a_i,
  input  logic                            level_b_i,
  input  logic [31:0]                     time_us_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic signed [31:0]              position_count_o,
  output logic signed [31:0]              speed_o,
  output logic                            speed_valid_o,
  output logic                            new_edge_seen_o,
  output logic                            moving_forward_o
);

  import qes_pkg::*;

  localparam int unsigned PW = (COUNT_WIDTH > POS_OUT_W) ? COUNT_WIDTH : POS_OUT_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_SLEW = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_ADD  = 3'd4;
  localparam logic [2:0] S_PUSH = 3'd5;

  logic [2:0] state_q, state_d;

  logic [SCALE_W-1:0] scale_q;
  logic [STEP_W-1:0]  step_q;
  logic [GAIN_W-1:0]  gain_q;
  logic               rev_q;

  logic [COUNT_WIDTH-1:0] pos_q, pos_d;
  logic [TIME_WIDTH-1:0]  rise_q, rise_d;
  logic [TIME_WIDTH-1:0]  period_q, period_d;
  logic                   fwd_q, fwd_d;
  logic                   pend_q, pend_d;
  logic signed [31:0]     filt_q, filt_d;
  logic signed [31:0]     last_raw_q, last_raw_d;
  logic signed [31:0]     raw_q, raw_d;
  logic signed [42:0]     prod_q, prod_d;

  logic               out_valid_q, out_valid_d;
  logic [31:0]        opos_q, opos_d;
  logic [31:0]        ospd_q, ospd_d;
  logic               osv_q, osv_d;
  logic               oflag_q, oflag_d;
  logic               ofwd_q, ofwd_d;

  logic                   out_free;
  logic                   in_acc;
  logic [TIME_WIDTH-1:0]  t;
  logic [TIME_WIDTH-1:0]  elapsed;
  logic [TIME_WIDTH-1:0]  dt;
  logic                   up;
  logic [COUNT_WIDTH-1:0] pos_step;
  logic [PW-1:0]          pos_ext;
  logic                   div_start;
  logic                   div_done;
  logic [SCALE_W-1:0]     mag;
  logic                   mag_big;
  logic signed [32:0]     hi;
  logic signed [32:0]     lo;
  logic signed [32:0]     raw_ext;
  logic signed [32:0]     diff;
  logic [GAIN_W-1:0]      geff;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign t       = time_us_i[TIME_WIDTH-1:0];
  assign elapsed = t - rise_q;
  assign dt      = (elapsed > period_q) ? elapsed : period_q;

  assign up       = ((action_i == ACT_EDGE_A) ? (level_a_i != level_b_i)
                                              : (level_a_i == level_b_i)) ^ rev_q;
  assign pos_step = up ? pos_q + 1'b1 : pos_q - 1'b1;

  assign mag_big = |mag[SCALE_W-1:31];
  assign hi      = $signed({last_raw_q[31], last_raw_q}) + $signed({2'b00, step_q});
  assign lo      = $signed({last_raw_q[31], last_raw_q}) - $signed({2'b00, step_q});
  assign raw_ext = {raw_q[31], raw_q};
  assign diff    = $signed({raw_q[31], raw_q}) - $signed({filt_q[31], filt_q});
  assign geff    = (gain_q > GAIN_ONE) ? GAIN_ONE : gain_q;

  qes_div #(
    .DVD_W (SCALE_W),
    .DVS_W (TIME_WIDTH)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (scale_q),
    .divisor_i  (dt),
    .done_o     (div_done),
    .quotient_o (mag)
  );

  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    rise_d      = rise_q;
    period_d    = period_q;
    fwd_d       = fwd_q;
    pend_d      = pend_q;
    filt_d      = filt_q;
    last_raw_d  = last_raw_q;
    raw_d       = raw_q;
    prod_d      = prod_q;
    div_start   = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    pos_ext     = PW'(pos_q);
    opos_d      = opos_q;
    ospd_d      = ospd_q;
    osv_d       = osv_q;
    oflag_d     = oflag_q;
    ofwd_d      = ofwd_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          ospd_d  = '0;
          osv_d   = 1'b0;
          oflag_d = 1'b0;
          unique case (action_i)
            ACT_EDGE_A, ACT_EDGE_B: begin
              pos_d = pos_step;
              fwd_d = up;
              if (action_i == ACT_EDGE_A && level_a_i) begin
                rise_d   = t;
                period_d = (rise_q != '0) ? elapsed : '0;
                pend_d   = 1'b1;
              end
            end
            ACT_SPEED: begin
              if (period_q != '0) begin
                div_start = 1'b1;
                state_d   = S_DIV;
              end
            end
            default: begin
              oflag_d = pend_q;
              pend_d  = 1'b0;
            end
          endcase
          if (state_d == S_IDLE) begin
            pos_ext     = PW'(pos_d);
            opos_d      = pos_ext[31:0];
            ofwd_d      = fwd_d;
            out_valid_d = 1'b1;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          if (fwd_q) begin
            raw_d = mag_big ? SPD_MAX : mag[31:0];
          end else begin
            raw_d = mag_big ? SPD_MIN : (~mag[31:0] + 32'd1);
          end
          state_d = S_SLEW;
        end
      end
      S_SLEW: begin
        priority if (raw_ext > hi) begin
          raw_d = hi[31:0];
        end else if (raw_ext < lo) begin
          raw_d = lo[31:0];
        end else begin
          raw_d = raw_q;
        end
        last_raw_d = raw_d;
        state_d    = S_MUL;
      end
      S_MUL: begin
        prod_d  = $signed({1'b0, geff}) * diff;
        state_d = S_ADD;
      end
      S_ADD: begin
        filt_d  = filt_q + prod_q[39:8];
        state_d = S_PUSH;
      end
      S_PUSH: begin
        if (out_free) begin
          opos_d      = pos_ext[31:0];
          ospd_d      = filt_q;
          osv_d       = 1'b1;
          oflag_d     = 1'b0;
          ofwd_d      = fwd_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      scale_q     <= SCALE_RST;
      step_q      <= STEP_RST;
      gain_q      <= GAIN_RST;
      rev_q       <= 1'b0;
      pos_q       <= '0;
      rise_q      <= '0;
      period_q    <= '0;
      fwd_q       <= 1'b1;
      pend_q      <= 1'b0;
      filt_q      <= '0;
      last_raw_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      rise_q      <= rise_d;
      period_q    <= period_d;
      fwd_q       <= fwd_d;
      pend_q      <= pend_d;
      filt_q      <= filt_d;
      last_raw_q  <= last_raw_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_SPEED_SCALE: scale_q <= cfg_data_i[SCALE_W-1:0];
          CFG_MAX_STEP:    step_q  <= cfg_data_i[STEP_W-1:0];
          CFG_FILT_GAIN:   gain_q  <= cfg_data_i[GAIN_W-1:0];
          default:         rev_q   <= cfg_data_i[0];
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    raw_q   <= raw_d;
    prod_q  <= prod_d;
    opos_q  <= opos_d;
    ospd_q  <= ospd_d;
    osv_q   <= osv_d;
    oflag_q <= oflag_d;
    ofwd_q  <= ofwd_d;
  end

  assign out_valid_o      = out_valid_q;
  assign position_count_o = opos_q;
  assign speed_o          = ospd_q;
  assign speed_valid_o    = osv_q;
  assign new_edge_seen_o  = oflag_q;
  assign moving_forward_o = ofwd_q;

endmodule

### design/qes_chk.sv
// Port-level checker for the quadrature encoder speed block, with its bind.
module qes_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [31:0] position_count_o,
  input logic signed [31:0] speed_o,
  input logic               speed_valid_o,
  input logic               new_edge_seen_o,
  input logic               moving_forward_o
);

  // speed reads zero unless the beat carries a valid speed
  a_speed_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !speed_valid_o |-> speed_o == 32'sd0)
    else $error("speed nonzero without speed_valid");

  // a beat is either a speed answer or a flag answer, never both
  a_flag_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(speed_valid_o && new_edge_seen_o))
    else $error("speed_valid and new_edge_seen both set");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(position_count_o) &&
      $stable(speed_o) && $stable(speed_valid_o) && $stable(new_edge_seen_o) &&
      $stable(moving_forward_o))
    else $error("stalled output beat changed");

endmodule

bind quadrature_encoder_speed_top qes_chk u_qes_chk (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .position_count_o (position_count_o),
  .speed_o          (speed_o),
  .speed_valid_o    (speed_valid_o),
  .new_edge_seen_o  (new_edge_seen_o),
  .moving_forward_o (moving_forward_o)
);
